// ----- hw/rtl/sssd_pkg.sv -----
// ---------------------------------------------------------------------------
// Seven-segment scan driver package
// Shared types, widths and the digit-to-segment decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package sssd_pkg;

  localparam int unsigned DIGIT_COUNT_DEF = 4;
  localparam int unsigned VALUE_W         = 14;
  localparam int unsigned EN_W            = 4;
  localparam int unsigned SEG_W           = 8;
  localparam int unsigned BIT_CNT_W       = 3;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Reciprocal of ten: (n * RECIP10) >> RECIP10_SHIFT == n / 10 for any 14-bit n.
  localparam int unsigned RECIP10       = 52429;
  localparam int unsigned RECIP10_SHIFT = 19;
  localparam int unsigned PROD_W        = 30;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_LOAD
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Largest number that the given count of decimal digits can show.
  function automatic int unsigned max_value(input int unsigned digits);
    int unsigned lim;
    lim = 1;
    for (int unsigned i = 0; i < digits; i++) begin
      lim = lim * 10;
    end
    return lim - 1;
  endfunction

  // Segment decoder, gfedcba in bits 6..0, decimal point (bit 7) never lit.
  function automatic logic [SEG_W-1:0] digit_segments(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h67;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sssd_in_if.sv -----
// ---------------------------------------------------------------------------
// Seven-segment scan driver input channel
// Valid/ready channel carrying one load or refresh transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface sssd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [sssd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sssd_out_if.sv -----
// ---------------------------------------------------------------------------
// Seven-segment scan driver output channel
// Valid/ready channel carrying one serial segment bit per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface sssd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      serial_bit;
  logic [sssd_pkg::EN_W-1:0] digit_enable_n;
  logic                      last;

  modport source (output valid, output serial_bit, output digit_enable_n, output last,
                  input ready);
  modport sink   (input valid, input serial_bit, input digit_enable_n, input last,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sssd_front.sv -----
// ---------------------------------------------------------------------------
// Seven-segment scan driver front end
// Accepts transactions, decodes the operation and saturates the number.
// ---------------------------------------------------------------------------
`default_nettype none

module sssd_front #(
  parameter int unsigned DIGIT_COUNT = sssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                         in_valid_i,
  input  logic                         in_op_i,
  input  logic [sssd_pkg::VALUE_W-1:0] in_value_i,
  output logic                         in_ready_o,
  input  sssd_pkg::q_status_t          q_stat_i,
  output logic                         push_o,
  output sssd_pkg::cmd_t               cmd_o
);

  localparam int unsigned Limit = sssd_pkg::max_value(DIGIT_COUNT);

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    cmd_o.op    = sssd_pkg::op_e'(in_op_i);
    cmd_o.value = in_value_i;
    // clamp to the largest number the display can show
    if (32'(in_value_i) > Limit) begin
      cmd_o.value = Limit[sssd_pkg::VALUE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sssd_queue.sv -----
// ---------------------------------------------------------------------------
// Seven-segment scan driver command queue
// Short FIFO between front end and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module sssd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sssd_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output sssd_pkg::cmd_t      cmd_o,
  output sssd_pkg::q_status_t stat_o
);

  localparam int unsigned Depth = sssd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sssd_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sssd_back.sv -----
// ---------------------------------------------------------------------------
// Seven-segment scan driver back end
// Splits loaded numbers into digits and shifts segment patterns out.
// ---------------------------------------------------------------------------
`default_nettype none

module sssd_back #(
  parameter int unsigned DIGIT_COUNT = sssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sssd_pkg::cmd_t            cmd_i,
  input  sssd_pkg::q_status_t       q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      serial_bit_o,
  output logic [sssd_pkg::EN_W-1:0] digit_enable_n_o,
  output logic                      last_o
);

  localparam int unsigned PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned VW   = sssd_pkg::VALUE_W;
  localparam int unsigned BW   = sssd_pkg::BIT_CNT_W;

  sssd_pkg::back_state_e state_q, state_d, start_state;

  logic [sssd_pkg::SEG_W-1:0] pat_q [DIGIT_COUNT];
  logic [PosW-1:0]            pos_q, dig_q;
  logic [BW-1:0]              bit_q;
  logic [VW-1:0]              num_q;

  logic                       out_valid_q, serial_bit_q, last_q;
  logic [sssd_pkg::EN_W-1:0]  en_n_q;

  logic                          out_free, emit, load_step, bit_last;
  logic [sssd_pkg::SEG_W-1:0]    cur_pat;
  logic [sssd_pkg::EN_W-1:0]     en_pos_n;
  logic [sssd_pkg::PROD_W-1:0]   prod;
  logic [VW-1:0]                 quot;
  logic [3:0]                    rem;

  assign out_free    = !out_valid_q || out_ready_i;
  assign bit_last    = (bit_q == BW'(7));
  assign cur_pat     = pat_q[pos_q];
  assign start_state = (cmd_i.op == sssd_pkg::OP_TICK) ? sssd_pkg::BK_SHIFT
                                                       : sssd_pkg::BK_LOAD;

  // divide by ten through the reciprocal
  assign prod = sssd_pkg::PROD_W'(num_q) * sssd_pkg::PROD_W'(sssd_pkg::RECIP10);
  assign quot = VW'(prod >> sssd_pkg::RECIP10_SHIFT);
  assign rem  = 4'(num_q - ((quot << 3) + (quot << 1)));

  always_comb begin
    for (int b = 0; b < sssd_pkg::EN_W; b++) begin
      en_pos_n[b] = (32'(pos_q) != b);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sssd_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) state_d = start_state;
      end
      sssd_pkg::BK_SHIFT: begin
        if (out_free && bit_last) begin
          state_d = q_stat_i.empty ? sssd_pkg::BK_IDLE : start_state;
        end
      end
      sssd_pkg::BK_LOAD: begin
        if (dig_q == '0) begin
          state_d = q_stat_i.empty ? sssd_pkg::BK_IDLE : start_state;
        end
      end
      default: state_d = sssd_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    load_step = 1'b0;
    unique case (state_q)
      sssd_pkg::BK_IDLE: begin
        pop_o = !q_stat_i.empty;
      end
      sssd_pkg::BK_SHIFT: begin
        emit  = out_free;
        pop_o = out_free && bit_last && !q_stat_i.empty;
      end
      sssd_pkg::BK_LOAD: begin
        load_step = 1'b1;
        pop_o     = (dig_q == '0) && !q_stat_i.empty;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sssd_pkg::BK_IDLE;
      pos_q       <= '0;
      dig_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        pat_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit) begin
        bit_q <= bit_q + 1'b1;
        if (bit_last) begin
          pos_q <= (pos_q == PosW'(DIGIT_COUNT - 1)) ? '0 : pos_q + 1'b1;
        end
      end
      if (load_step) begin
        pat_q[dig_q] <= sssd_pkg::digit_segments(rem);
        dig_q        <= dig_q - 1'b1;
      end
      if (pop_o) begin
        if (cmd_i.op == sssd_pkg::OP_LOAD) begin
          dig_q <= PosW'(DIGIT_COUNT - 1);
        end else begin
          bit_q <= '0;
        end
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_step) begin
      num_q <= quot;
    end
    if (pop_o && cmd_i.op == sssd_pkg::OP_LOAD) begin
      num_q <= cmd_i.value;
    end
    if (emit) begin
      serial_bit_q <= cur_pat[~bit_q];
      last_q       <= bit_last;
      en_n_q       <= bit_last ? en_pos_n : '1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign serial_bit_o     = serial_bit_q;
  assign digit_enable_n_o = en_n_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/seven_segment_scan_driver_core.sv -----
// A tick's first serial bit passes the command queue, back-end state and output register.
// A refresh tick shifts out eight segment bits, one per cycle while the output is free;
//   a load has the digit splitter yield DIGIT_COUNT digits, one divide-by-ten per cycle.
// Input is taken while the two-entry command queue has room.
// Reset: asynchronous, clears patterns to blank, scan position to the leftmost digit.
// ---------------------------------------------------------------------------
// Seven-segment scan driver core
// Multiplexed display driver: loads a number, then shifts one digit per tick.
// ---------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_driver_core #(
  parameter int unsigned DIGIT_COUNT = sssd_pkg::DIGIT_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sssd_in_if.sink           in_i,
  sssd_out_if.source        out_o
);

  // Front end to queue: classified command and push strobe
  sssd_pkg::cmd_t      front_cmd, queue_cmd;
  sssd_pkg::q_status_t q_stat;
  logic                q_push, q_pop;

  // Front end: take a transaction whenever the queue has room, saturate the number
  sssd_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_value_i (in_i.value),
    .in_ready_o (in_i.ready),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  // Queue: lets the front keep accepting while the back shifts or splits digits
  sssd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (front_cmd),
    .pop_i  (q_pop),
    .cmd_o  (queue_cmd),
    .stat_o (q_stat)
  );

  // Back end: digit splitter, pattern store, serial shifter and output register
  sssd_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (queue_cmd),
    .q_stat_i         (q_stat),
    .pop_o            (q_pop),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .serial_bit_o     (out_o.serial_bit),
    .digit_enable_n_o (out_o.digit_enable_n),
    .last_o           (out_o.last)
  );

`ifndef SYNTH
  // Never write into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("command queue overflow");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("command queue underflow");

  // Digits stay dark while bits shift in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last |-> out_o.digit_enable_n == '1)
    else $error("digit enabled before latch");

  // At the latch at most one digit is enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> $countones(~out_o.digit_enable_n) <= 1)
    else $error("more than one digit enabled");
`endif

endmodule

`default_nettype wire
